[hdl/tprdm_pkg.sv]
package tprdm_pkg;

  localparam int MAX_SOURCE_DIM_DEF = 8192;
  localparam int MAX_THUMB_DIM_DEF  = 1024;

  localparam int SRC_W_BITS   = 14;
  localparam int THUMB_W_BITS = 11;
  localparam int GPP_BITS     = 12;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 14;

  localparam logic [SRC_W_BITS-1:0]   SRC_WIDTH_RST   = 14'd1920;
  localparam logic [SRC_W_BITS-1:0]   SRC_HEIGHT_RST  = 14'd1080;
  localparam logic [THUMB_W_BITS-1:0] THUMB_WIDTH_RST = 11'd320;
  localparam logic [THUMB_W_BITS-1:0] THUMB_HEIGHT_RST = 11'd180;
  localparam logic [GPP_BITS-1:0]     GPP_RST         = 12'd252;

  localparam logic signed [16:0] KY  = 17'sd19077;
  localparam logic signed [16:0] KRV = 17'sd29372;
  localparam logic signed [16:0] KGU = 17'sd3493;
  localparam logic signed [16:0] KGV = 17'sd8731;
  localparam logic signed [16:0] KBU = 17'sd34610;
  localparam logic [31:0] HASH_K = 32'h045d_9f3b;
  localparam logic [9:0] LUMA_OFS   = 10'd64;
  localparam logic [9:0] CHROMA_OFS = 10'd512;
  localparam logic signed [31:0] ROUND_HALF = 32'sd32768;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SRC_WIDTH    = 3'd0,
    CFG_SRC_HEIGHT   = 3'd1,
    CFG_THUMB_WIDTH  = 3'd2,
    CFG_THUMB_HEIGHT = 3'd3,
    CFG_GPP          = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_HASH, S_EMIT, S_LMUL, S_LCHK
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic hash;
    logic emit;
    logic lmul;
    logic lchk;
  } cmd_t;

  typedef struct packed {
    logic chosen;
    logic out_stall;
    logic line_end;
  } status_t;

  function automatic logic [7:0] to_8bit(input logic signed [31:0] acc);
    logic signed [31:0] v;
    v = (acc + ROUND_HALF) >>> 16;
    if (v < 0) return 8'd0;
    else if (v > 32'sd255) return 8'd255;
    else return v[7:0];
  endfunction

endpackage

[hdl/tprdm_ctrl.sv]
module tprdm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  tprdm_pkg::status_t st,
  output tprdm_pkg::cmd_t    cmd
);

  tprdm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tprdm_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      tprdm_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt = tprdm_pkg::S_MUL;
        end
      end
      tprdm_pkg::S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = tprdm_pkg::S_HASH;
      end
      tprdm_pkg::S_HASH: begin
        cmd.hash = 1'b1;
        state_nxt = tprdm_pkg::S_EMIT;
      end
      tprdm_pkg::S_EMIT: begin
        if (!(st.chosen && st.out_stall)) begin
          cmd.emit = 1'b1;
          state_nxt = st.line_end ? tprdm_pkg::S_LMUL : tprdm_pkg::S_IDLE;
        end
      end
      tprdm_pkg::S_LMUL: begin
        cmd.lmul = 1'b1;
        state_nxt = tprdm_pkg::S_LCHK;
      end
      tprdm_pkg::S_LCHK: begin
        cmd.lchk = 1'b1;
        state_nxt = tprdm_pkg::S_IDLE;
      end
      default: state_nxt = tprdm_pkg::S_IDLE;
    endcase
  end

endmodule

[hdl/tprdm_dp.sv]
module tprdm_dp #(
  parameter int MAX_SOURCE_DIM = tprdm_pkg::MAX_SOURCE_DIM_DEF,
  parameter int MAX_THUMB_DIM  = tprdm_pkg::MAX_THUMB_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [tprdm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tprdm_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic [31:0]                         in_tdata,
  input  logic [2:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [71:0]                         out_tdata,
  output logic                                out_tlast,
  input  tprdm_pkg::cmd_t                     cmd,
  output tprdm_pkg::status_t                  st
);

  localparam int SW  = $clog2(MAX_SOURCE_DIM + 1);
  localparam int SCW = $clog2(MAX_SOURCE_DIM);
  localparam int CW  = $clog2(MAX_THUMB_DIM + 1);
  localparam int PW  = SW + CW;

  logic [tprdm_pkg::SRC_W_BITS-1:0]   src_width_r, src_height_r;
  logic [tprdm_pkg::THUMB_W_BITS-1:0] thumb_width_r, thumb_height_r;
  logic [tprdm_pkg::GPP_BITS-1:0]     gpp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r    <= tprdm_pkg::SRC_WIDTH_RST;
      src_height_r   <= tprdm_pkg::SRC_HEIGHT_RST;
      thumb_width_r  <= tprdm_pkg::THUMB_WIDTH_RST;
      thumb_height_r <= tprdm_pkg::THUMB_HEIGHT_RST;
      gpp_r          <= tprdm_pkg::GPP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tprdm_pkg::CFG_SRC_WIDTH:    src_width_r    <= cfg_data;
        tprdm_pkg::CFG_SRC_HEIGHT:   src_height_r   <= cfg_data;
        tprdm_pkg::CFG_THUMB_WIDTH:  thumb_width_r  <= cfg_data[10:0];
        tprdm_pkg::CFG_THUMB_HEIGHT: thumb_height_r <= cfg_data[10:0];
        tprdm_pkg::CFG_GPP:          gpp_r          <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [15:0] sw_x, sh_x, tw_hi, th_hi, tw_x, th_x;
  logic [SW-1:0] sw, sh;
  logic [CW-1:0] tw, th;
  logic [tprdm_pkg::GPP_BITS-1:0] gpp;

  always_comb begin
    sw_x = {2'b0, src_width_r};
    if (sw_x < 16'd2) sw_x = 16'd2;
    else if (sw_x > 16'(MAX_SOURCE_DIM)) sw_x = 16'(MAX_SOURCE_DIM);
    sw_x[0] = 1'b0;
    sh_x = {2'b0, src_height_r};
    if (sh_x < 16'd1) sh_x = 16'd1;
    else if (sh_x > 16'(MAX_SOURCE_DIM)) sh_x = 16'(MAX_SOURCE_DIM);
    tw_hi = (sw_x < 16'(MAX_THUMB_DIM)) ? sw_x : 16'(MAX_THUMB_DIM);
    th_hi = (sh_x < 16'(MAX_THUMB_DIM)) ? sh_x : 16'(MAX_THUMB_DIM);
    tw_x = {5'b0, thumb_width_r};
    if (tw_x < 16'd1) tw_x = 16'd1;
    else if (tw_x > tw_hi) tw_x = tw_hi;
    th_x = {5'b0, thumb_height_r};
    if (th_x < 16'd1) th_x = 16'd1;
    else if (th_x > th_hi) th_x = th_hi;
    sw = SW'(sw_x);
    sh = SW'(sh_x);
    tw = CW'(tw_x);
    th = CW'(th_x);
    gpp = (gpp_r == '0) ? tprdm_pkg::GPP_BITS'(1) : gpp_r;
  end

  // position state
  logic [SCW-1:0] source_col_r, source_line_r;
  logic [CW-1:0]  next_col_r, next_line_r;
  logic           line_chosen_r;
  logic [tprdm_pkg::GPP_BITS-1:0] gip_r;
  logic [31:0]    packet_index_r, frame_count_r;

  // captured word
  logic [9:0] luma_r, cb_r, cr_r;
  logic       corrupt_r, mute_m_r, mute_b_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      luma_r    <= in_tdata[9:0];
      cb_r      <= in_tdata[19:10];
      cr_r      <= in_tdata[29:20];
      corrupt_r <= in_tuser[0];
      mute_m_r  <= in_tuser[1];
      mute_b_r  <= in_tuser[2];
    end
  end

  // products
  logic [PW-1:0] pcol_r, qcol_r, pline_r, qline_r;
  logic signed [31:0] py_r, prv_r, pgu_r, pgv_r, pbu_r;
  logic [31:0] h1_r, h2_r;
  logic [7:0]  red_r, green_r, blue_r;
  logic signed [10:0] y_s, cb_s, cr_s;
  logic [31:0] hx0, hs1, hs2;

  always_comb begin
    y_s  = $signed({1'b0, luma_r}) - $signed({1'b0, tprdm_pkg::LUMA_OFS});
    cb_s = $signed({1'b0, cb_r}) - $signed({1'b0, tprdm_pkg::CHROMA_OFS});
    cr_s = $signed({1'b0, cr_r}) - $signed({1'b0, tprdm_pkg::CHROMA_OFS});
    hx0  = packet_index_r ^ frame_count_r;
    hs1  = hx0 ^ (hx0 >> 16);
    hs2  = h1_r ^ (h1_r >> 16);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pcol_r <= PW'(next_col_r) * PW'(sw);
      qcol_r <= PW'(source_col_r) * PW'(tw);
      py_r   <= 32'(tprdm_pkg::KY * y_s);
      prv_r  <= 32'(tprdm_pkg::KRV * cr_s);
      pgu_r  <= 32'(tprdm_pkg::KGU * cb_s);
      pgv_r  <= 32'(tprdm_pkg::KGV * cr_s);
      pbu_r  <= 32'(tprdm_pkg::KBU * cb_s);
      h1_r   <= hs1 * tprdm_pkg::HASH_K;
    end
    if (cmd.hash) begin
      h2_r    <= hs2 * tprdm_pkg::HASH_K;
      red_r   <= tprdm_pkg::to_8bit(py_r + prv_r);
      green_r <= tprdm_pkg::to_8bit(py_r - pgu_r - pgv_r);
      blue_r  <= tprdm_pkg::to_8bit(py_r + pbu_r);
    end
    if (cmd.lmul) begin
      pline_r <= PW'(next_line_r) * PW'(sh);
      qline_r <= PW'(source_line_r) * PW'(th);
    end
  end

  // emit decision and counter updates
  logic chosen, line_end, frame_end, drop_m, keep_m, keep_b;
  logic [PW:0] qcol_tw, qline_th;
  logic [SW-1:0] col_inc, line_inc;
  logic [tprdm_pkg::GPP_BITS:0] gip_inc;

  always_comb begin
    qcol_tw   = {1'b0, qcol_r} + (PW+1)'(tw);
    qline_th  = {1'b0, qline_r} + (PW+1)'(th);
    chosen    = line_chosen_r && (next_col_r < tw) && (qcol_r <= pcol_r) &&
                ({1'b0, pcol_r} < qcol_tw);
    col_inc   = SW'(source_col_r) + SW'(1);
    line_inc  = SW'(source_line_r) + SW'(1);
    line_end  = col_inc >= sw;
    frame_end = line_inc >= sh;
    gip_inc   = {1'b0, gip_r} + (tprdm_pkg::GPP_BITS+1)'(1);
    drop_m    = corrupt_r && !(h2_r[0] ^ h2_r[16]);
    keep_m    = !mute_m_r && !drop_m;
    keep_b    = !mute_b_r && !(corrupt_r && !drop_m);
    st.chosen    = chosen;
    st.line_end  = line_end;
    st.out_stall = out_tvalid && !out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_col_r   <= '0;
      source_line_r  <= '0;
      next_col_r     <= '0;
      next_line_r    <= '0;
      line_chosen_r  <= 1'b1;
      gip_r          <= '0;
      packet_index_r <= '0;
      frame_count_r  <= '0;
    end else begin
      if (cmd.emit) begin
        logic [CW-1:0] ncol;
        logic [tprdm_pkg::GPP_BITS-1:0] ngip;
        logic [31:0] npkt;
        ncol = chosen ? next_col_r + CW'(1) : next_col_r;
        ngip = gip_r;
        npkt = packet_index_r;
        if (source_col_r[0]) begin
          if (gip_inc >= {1'b0, gpp}) begin
            ngip = '0;
            npkt = packet_index_r + 32'd1;
          end else begin
            ngip = gip_inc[tprdm_pkg::GPP_BITS-1:0];
          end
        end
        if (line_end) begin
          source_col_r <= '0;
          next_col_r   <= '0;
          if (frame_end) begin
            source_line_r  <= '0;
            next_line_r    <= '0;
            gip_r          <= '0;
            packet_index_r <= '0;
            if (!(mute_m_r && mute_b_r)) frame_count_r <= frame_count_r + 32'd1;
          end else begin
            source_line_r  <= SCW'(line_inc);
            if (line_chosen_r) next_line_r <= next_line_r + CW'(1);
            gip_r          <= ngip;
            packet_index_r <= npkt;
          end
        end else begin
          source_col_r   <= SCW'(col_inc);
          next_col_r     <= ncol;
          gip_r          <= ngip;
          packet_index_r <= npkt;
        end
      end
      if (cmd.lchk) begin
        line_chosen_r <= (next_line_r < th) && (qline_r <= pline_r) &&
                         ({1'b0, pline_r} < qline_th);
      end
    end
  end

  // result register
  logic        out_valid_r;
  logic [71:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit && chosen) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && chosen) begin
      out_data_r <= {4'b0, 10'(next_line_r), 10'(next_col_r),
                     keep_b ? blue_r : 8'd0, keep_b ? green_r : 8'd0,
                     keep_b ? red_r : 8'd0,
                     keep_m ? blue_r : 8'd0, keep_m ? green_r : 8'd0,
                     keep_m ? red_r : 8'd0};
      out_last_r <= (next_col_r == tw - CW'(1)) && (next_line_r == th - CW'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[hdl/thumbnail_pixel_rgb_drop_mask_core.sv]
// Thumbnail pixel path: picks nearest-neighbor source pixels of a 4:2:2
// 10-bit picture, converts BT.709 YCbCr to 8-bit RGB, and emits a main and
// a backup copy, with optional complementary packet-drop blanking.
// Input stream: one source pixel per word, raster order. Only chosen pixels
// produce an output word; tlast marks the last thumbnail pixel of a frame.
// Config channel: cfg_index selects src_width, src_height, thumb_width,
// thumb_height, groups_per_packet (0..4095); cfg_ready is always high. Write
// only while the block is idle.
// Each input word passes through accept, multiply, hash/convert and update;
// on the last pixel of a source line the line-select multiply and check
// follow. The multi-cycle controller takes the next word only after these.
// The result is registered in the update step.
// Reset (rst_n low, synchronous) restores register defaults and clears all
// counters; the first source line is selected.
// A stalled receiver holds the output word; the next input word is still
// taken and processed, and the block waits only when a new result is ready
// while the previous one has not been taken.
module thumbnail_pixel_rgb_drop_mask_core #(
  parameter int MAX_SOURCE_DIM = tprdm_pkg::MAX_SOURCE_DIM_DEF,
  parameter int MAX_THUMB_DIM  = tprdm_pkg::MAX_THUMB_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tprdm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tprdm_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [31:0]                         in_tdata,  // luma, chroma_blue, chroma_red
  input  logic [2:0]                          in_tuser,  // corrupt_mode, mute_main, mute_backup
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // main_red, main_green, main_blue, backup_red, backup_green, backup_blue,
  // thumb_col, thumb_line
  output logic [71:0]                         out_tdata,
  output logic                                out_tlast   // frame_done
);

  tprdm_pkg::cmd_t    cmd;
  tprdm_pkg::status_t st;

  assign cfg_ready = 1'b1;

  tprdm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tprdm_dp #(
    .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
    .MAX_THUMB_DIM  (MAX_THUMB_DIM)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

[sim/thumbnail_pixel_rgb_drop_mask_core_test.sv]
`timescale 1ns / 1ps

module thumbnail_pixel_rgb_drop_mask_core_test;

  // most significant field first: bit 0 is frame_done, then out_tdata from bit 0 up
  typedef struct packed {
    logic [9:0] line, col;
    logic [7:0] bkp_b, bkp_g, bkp_r, main_b, main_g, main_r;
    logic       done;
  } thumb_px_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  tprdm_pkg::cfg_idx_t   cfg_index;
  logic [13:0]           cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;   // luma, chroma_blue, chroma_red
  logic [2:0]            in_tuser;   // corrupt_mode, mute_main, mute_backup
  logic                  out_tvalid;
  logic                  out_tready;
  logic [71:0]           out_tdata;  // main r/g/b, backup r/g/b, thumb_col, thumb_line
  logic                  out_tlast;  // frame_done

  thumbnail_pixel_rgb_drop_mask_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // register shadow
  int unsigned reg_sw, reg_sh, reg_tw, reg_th, reg_gpp;
  // pixel walker state
  int unsigned src_x, src_y, pick_col, pick_line, groups_seen;
  bit          row_taken;
  bit [31:0]   pkt_num, frame_num;

  thumb_px_t   expected_px[$];
  int          errors;
  int          words_in, words_out, drop_words;
  int          idle_pct, stall_pct;
  bit          hold_req;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [7:0] sat8(int acc);
    int v;
    v = (acc + 32768) >>> 16;
    return v < 0 ? 8'd0 : (v > 255 ? 8'd255 : v[7:0]);
  endfunction

  function automatic logic [31:0] scramble(logic [31:0] x);
    x = x ^ (x >> 16);
    x = x * tprdm_pkg::HASH_K;
    x = x ^ (x >> 16);
    x = x * tprdm_pkg::HASH_K;
    return x ^ (x >> 16);
  endfunction

  task automatic predict_thumb_px(logic [9:0] luma, logic [9:0] cb, logic [9:0] cr,
                                  logic [2:0] flags);
    int unsigned sw, sh, tw, th, gpp;
    int y, u, v;
    logic [7:0] r, g, b;
    bit drop_m, drop_b, keep_m, keep_b;
    thumb_px_t px;
    sw = clamp_dim(reg_sw, 2, tprdm_pkg::MAX_SOURCE_DIM_DEF) & ~32'd1;
    sh = clamp_dim(reg_sh, 1, tprdm_pkg::MAX_SOURCE_DIM_DEF);
    tw = clamp_dim(reg_tw, 1, sw < tprdm_pkg::MAX_THUMB_DIM_DEF ?
                   sw : tprdm_pkg::MAX_THUMB_DIM_DEF);
    th = clamp_dim(reg_th, 1, sh < tprdm_pkg::MAX_THUMB_DIM_DEF ?
                   sh : tprdm_pkg::MAX_THUMB_DIM_DEF);
    gpp = reg_gpp == 0 ? 1 : reg_gpp;
    y = int'(luma) - 64;
    u = int'(cb) - 512;
    v = int'(cr) - 512;
    if (row_taken && pick_col < tw && src_x == pick_col * sw / tw) begin
      r = sat8(19077 * y + 29372 * v);
      g = sat8(19077 * y - 3493 * u - 8731 * v);
      b = sat8(19077 * y + 34610 * u);
      drop_m = 0;
      drop_b = 0;
      if (flags[0]) begin
        drop_m = scramble(pkt_num ^ frame_num) % 2 == 0;
        drop_b = !drop_m;
        drop_words++;
      end
      keep_m = !flags[1] && !drop_m;
      keep_b = !flags[2] && !drop_b;
      px.main_r = keep_m ? r : 8'd0;
      px.main_g = keep_m ? g : 8'd0;
      px.main_b = keep_m ? b : 8'd0;
      px.bkp_r = keep_b ? r : 8'd0;
      px.bkp_g = keep_b ? g : 8'd0;
      px.bkp_b = keep_b ? b : 8'd0;
      px.col = pick_col[9:0];
      px.line = pick_line[9:0];
      px.done = pick_col == tw - 1 && pick_line == th - 1;
      expected_px.push_back(px);
      pick_col++;
    end
    if (src_x % 2 == 1) begin
      groups_seen++;
      if (groups_seen >= gpp) begin
        groups_seen = 0;
        pkt_num++;
      end
    end
    if (src_x + 1 >= sw) begin
      src_x = 0;
      pick_col = 0;
      if (row_taken) pick_line++;
      if (src_y + 1 >= sh) begin
        src_y = 0;
        pick_line = 0;
        groups_seen = 0;
        pkt_num = 0;
        if (!(flags[1] && flags[2])) frame_num++;
      end else begin
        src_y++;
      end
      row_taken = pick_line < th && src_y == pick_line * sh / th;
    end else begin
      src_x++;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic send_pixel(logic [9:0] luma, logic [9:0] cb, logic [9:0] cr, logic [2:0] flags);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, cr, cb, luma};
    in_tuser <= flags;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_in++;
    predict_thumb_px(luma, cb, cr, flags);
  endtask

  task automatic send_random(int n);
    logic [2:0] f;
    repeat (n) begin
      f[0] = 1'($urandom_range(1));
      f[1] = $urandom_range(3) == 0;
      f[2] = $urandom_range(3) == 0;
      send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                 10'($urandom_range(1023)), f);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_px.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(tprdm_pkg::cfg_idx_t idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[13:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tprdm_pkg::CFG_SRC_WIDTH:    reg_sw = value & 32'h3FFF;
      tprdm_pkg::CFG_SRC_HEIGHT:   reg_sh = value & 32'h3FFF;
      tprdm_pkg::CFG_THUMB_WIDTH:  reg_tw = value & 32'h7FF;
      tprdm_pkg::CFG_THUMB_HEIGHT: reg_th = value & 32'h7FF;
      tprdm_pkg::CFG_GPP:          reg_gpp = value & 32'hFFF;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned tw,
                              int unsigned th, int unsigned gpp);
    write_reg(tprdm_pkg::CFG_SRC_WIDTH, sw);
    write_reg(tprdm_pkg::CFG_SRC_HEIGHT, sh);
    write_reg(tprdm_pkg::CFG_THUMB_WIDTH, tw);
    write_reg(tprdm_pkg::CFG_THUMB_HEIGHT, th);
    write_reg(tprdm_pkg::CFG_GPP, gpp);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_req && $urandom_range(99) >= stall_pct;
    end
  end

  // long receiver hold-off
  always begin
    wait (hold_req);
    repeat (400) @(posedge clk);
    hold_req = 0;
  end

  always @(posedge clk) begin
    thumb_px_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[67:0], out_tlast};
      words_out++;
      if (expected_px.size() == 0) begin
        report_mismatch("unexpected word, col", int'(got.col), -1);
      end else begin
        want = expected_px.pop_front();
        if (got.main_r !== want.main_r)
          report_mismatch("main_red", int'(got.main_r), int'(want.main_r));
        if (got.main_g !== want.main_g)
          report_mismatch("main_green", int'(got.main_g), int'(want.main_g));
        if (got.main_b !== want.main_b)
          report_mismatch("main_blue", int'(got.main_b), int'(want.main_b));
        if (got.bkp_r !== want.bkp_r)
          report_mismatch("backup_red", int'(got.bkp_r), int'(want.bkp_r));
        if (got.bkp_g !== want.bkp_g)
          report_mismatch("backup_green", int'(got.bkp_g), int'(want.bkp_g));
        if (got.bkp_b !== want.bkp_b)
          report_mismatch("backup_blue", int'(got.bkp_b), int'(want.bkp_b));
        if (got.col !== want.col)
          report_mismatch("thumb_col", int'(got.col), int'(want.col));
        if (got.line !== want.line)
          report_mismatch("thumb_line", int'(got.line), int'(want.line));
        if (got.done !== want.done)
          report_mismatch("frame_done", int'(got.done), int'(want.done));
      end
    end
  end

  task automatic test_directed_extremes();
    set_geometry(4, 2, 4, 2, 1);
    send_pixel(10'd0, 10'd0, 10'd0, 3'b000);
    send_pixel(10'd1023, 10'd1023, 10'd1023, 3'b000);
    send_pixel(10'd1023, 10'd0, 10'd1023, 3'b000);
    send_pixel(10'd64, 10'd512, 10'd512, 3'b000);
    send_pixel(10'd940, 10'd512, 10'd512, 3'b010);
    send_pixel(10'd500, 10'd1023, 10'd0, 3'b100);
    send_pixel(10'd700, 10'd0, 10'd1023, 3'b110);
    send_pixel(10'd300, 10'd200, 10'd800, 3'b110);  // frame end, both muted
    for (int i = 0; i < 8; i++)
      send_pixel(10'(512 + i), 10'(100 * i), 10'(1023 - 90 * i), 3'b001);
    send_pixel(10'd1023, 10'd1023, 10'd0, 3'b011);
    send_pixel(10'd0, 10'd0, 10'd1023, 3'b101);
    send_pixel(10'd800, 10'd300, 10'd700, 3'b111);
    send_pixel(10'd800, 10'd300, 10'd700, 3'b001);
    wait_drained();
  endtask

  task automatic test_register_clamps();
    set_geometry(7, 3, 9, 5, 0);  // odd width, thumbnail larger than source, gpp zero
    send_random(42);
    wait_drained();
    set_geometry(0, 0, 0, 0, 3);  // all dimensions below range
    send_random(12);
    wait_drained();
  endtask

  task automatic test_random_frames();
    int unsigned sw, sh;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = ph == 1 || ph == 3 ? (ph == 1 ? 62 : 34) : 0;
      stall_pct = ph == 2 || ph == 3 ? (ph == 2 ? 62 : 34) : 0;
      for (int k = 0; k < 3; k++) begin
        sw = $urandom_range(24, 2);
        sh = $urandom_range(8, 1);
        set_geometry(sw, sh, $urandom_range(sw + 2, 1), $urandom_range(sh + 2, 1),
                     $urandom_range(5));
        send_random($urandom_range(40, 25));
        wait_drained();
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_geometry(4, 4, 4, 4, 2);
    hold_req = 1;
    send_random(64);
    wait_drained();
  endtask

  task automatic test_wide_line();
    set_geometry(16383, 0, 2047, 1, 4095);  // widest source, one line
    send_random(32);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = tprdm_pkg::CFG_SRC_WIDTH;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    hold_req = 0;
    idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    words_in = 0;
    words_out = 0;
    drop_words = 0;
    reg_sw = 1920;
    reg_sh = 1080;
    reg_tw = 320;
    reg_th = 180;
    reg_gpp = 252;
    src_x = 0;
    src_y = 0;
    pick_col = 0;
    pick_line = 0;
    row_taken = 1;
    groups_seen = 0;
    pkt_num = 0;
    frame_num = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_register_clamps();
    test_random_frames();
    test_backpressure();
    test_wide_line();

    $display("covered %0d source pixels, %0d thumbnail words (%0d with drop masking),",
             words_in, words_out, drop_words);
    $display("clamped and odd sizes, idle/stall mixes and a long output hold-off");
    if (errors == 0 && expected_px.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
hdl/tprdm_pkg.sv
hdl/tprdm_ctrl.sv
hdl/tprdm_dp.sv
hdl/thumbnail_pixel_rgb_drop_mask_core.sv
sim/thumbnail_pixel_rgb_drop_mask_core_test.sv
